[design/htld_pkg.sv]
// ----------------------------------------------------------------------------
// Huffman tree load and decode: shared package
// Constants, error codes and state encodings used by the decoder modules.
// ----------------------------------------------------------------------------
package htld_pkg;

    localparam int NODE_ENTRIES_DEF  = 512;
    localparam int STACK_ENTRIES_DEF = 256;
    localparam int BITS_PER_BYTE     = 8;

    localparam logic [7:0] CH_LEAF = 8'h31;
    localparam logic [7:0] CH_JOIN = 8'h30;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_NO_TREE   = 3'd3,
        ERR_TABLE     = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_WRITE,
        ST_READ,
        ST_STEP,
        ST_EMIT,
        ST_FLUSH
    } t_state;

endpackage

[design/huffman_tree_load_and_decode.sv]
// ----------------------------------------------------------------------------
// Huffman tree load and decode
// Rebuilds a code tree from a post-order byte serialization and decodes
// compressed bytes against it, one tree step per data bit.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_valid/o_ready with i_action and i_byte_value.
// Action 0 bytes build the tree; action 1 bytes are decoded MSB first. Each
// emitted symbol or error leaves on o_valid/i_ready with o_symbol, o_last,
// o_message_done and o_error_code. i_cfg_we writes the symbol count, which
// is sampled when the tree root is set.
// Sequencing: a leaf or ignored tree byte is handled in ST_IDLE alone, a root
// join passes through ST_POP and a merging join through ST_POP and ST_WRITE
// (the stack reads and the node write take separate steps). An error result is
// loaded at the accepting edge. Each data bit passes through ST_READ (node read),
// ST_STEP (child read) and ST_EMIT (leaf check), with the byte held in a shift
// register. A symbol is held until the walk knows whether it is the last one of
// the byte; the last leaves through ST_FLUSH. A new request is taken only once
// the byte is done and the state machine is back in ST_IDLE.
// Reset clears all control state; the node table and stack are only read at
// entries written since. When the receiver stalls, the walk holds at the
// pending result, and no request is taken while a result waits.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode
    import htld_pkg::*;
#(
    parameter int NODE_ENTRIES  = NODE_ENTRIES_DEF,
    parameter int STACK_ENTRIES = STACK_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_byte_value,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_symbol,
    output logic        o_last,
    output logic        o_message_done,
    output logic [2:0]  o_error_code
);
    localparam int NW = $clog2(NODE_ENTRIES);
    localparam int SW = $clog2(STACK_ENTRIES);
    localparam int NE = 1 + 8 + 2 * NW;

    // Memories: node entry is {leaf, sym, left, right}.
    logic [NE-1:0] r_nodes [NODE_ENTRIES];
    logic [NW-1:0] r_stack [STACK_ENTRIES];

    t_state r_state, n_state;
    logic [NW:0]   r_ncount;
    logic [SW:0]   r_depth;
    logic          r_expect, r_ready_tree, r_finished;
    logic [NW-1:0] r_root, r_cur;
    logic [31:0]   r_remain, r_count_cfg;
    logic [7:0]    r_shift;
    logic [3:0]    r_bits;
    logic          r_osym_valid;
    logic [7:0]    r_sym;
    logic          r_done;
    logic [NE-1:0] r_rdata;
    logic [NW-1:0] r_sdata, r_right;

    logic          accept, slot_free, leaf_push, step_stay, leaf_done, emit_go;
    t_err          req_err;
    logic          node_leaf;
    logic [7:0]    node_sym;
    logic [NW-1:0] node_l, node_r, nx;
    logic [31:0]   remain_dec;
    logic          out_load, n_out_valid, n_last, n_done;
    logic [7:0]    n_symbol;
    t_err          n_err;
    logic          node_we, node_re, stack_we, stack_re;
    logic [NW-1:0] node_waddr, node_raddr, stack_wdata;
    logic [NE-1:0] node_wdata;
    logic [SW-1:0] stack_waddr, stack_raddr;

    assign accept     = i_valid && o_ready;
    assign o_ready    = (r_state == ST_IDLE) && !o_valid;
    assign slot_free  = !o_valid || i_ready;
    assign node_leaf  = r_rdata[NE-1];
    assign node_sym   = r_rdata[NE-2 -: 8];
    assign node_l     = r_rdata[2*NW-1 -: NW];
    assign node_r     = r_rdata[NW-1:0];
    assign nx         = r_shift[7] ? node_r : node_l;
    assign remain_dec = r_remain - 32'd1;
    // A tree whose root is a leaf never moves off the root.
    assign step_stay  = (r_cur == r_root) && node_leaf;
    assign leaf_done  = (r_remain == 32'd1);
    // A new leaf can only be taken once the held symbol has left.
    assign emit_go    = !node_leaf || !r_osym_valid || slot_free;
    assign leaf_push  = accept && !i_action && !r_ready_tree && r_expect
                        && (req_err == ERR_NONE);
    assign n_out_valid = out_load || (o_valid && !i_ready);

    always_comb begin
        req_err = ERR_NONE;
        if (i_action) begin
            if (!r_ready_tree) req_err = ERR_NO_TREE;
        end else if (!r_ready_tree) begin
            if (r_expect) begin
                if (r_depth >= (SW+1)'(STACK_ENTRIES)) begin
                    req_err = ERR_OVERFLOW;
                end else if (r_ncount >= (NW+1)'(NODE_ENTRIES)) begin
                    req_err = ERR_TABLE;
                end
            end else if (i_byte_value == CH_JOIN) begin
                if (r_depth == '0) begin
                    req_err = ERR_UNDERFLOW;
                end else if (r_depth != (SW+1)'(1)
                             && r_ncount >= (NW+1)'(NODE_ENTRIES)) begin
                    req_err = ERR_TABLE;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && req_err == ERR_NONE) begin
                    if (i_action) begin
                        if (!r_finished) n_state = ST_READ;
                    end else if (!r_ready_tree && !r_expect && i_byte_value == CH_JOIN) begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP:   n_state = (r_depth == (SW+1)'(1)) ? ST_IDLE : ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            ST_READ:  n_state = ST_STEP;
            ST_STEP:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (!node_leaf) begin
                    if (r_bits != 4'd0) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = r_osym_valid ? ST_FLUSH : ST_IDLE;
                    end
                end else if (emit_go) begin
                    n_state = (leaf_done || r_bits == 4'd0) ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: if (slot_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        out_load = 1'b0;
        n_symbol = r_sym;
        n_last   = 1'b1;
        n_done   = r_done;
        n_err    = ERR_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && req_err != ERR_NONE) begin
                    out_load = 1'b1;
                    n_symbol = 8'd0;
                    n_done   = 1'b0;
                    n_err    = req_err;
                end
            end
            ST_EMIT: begin
                // Another leaf follows in this byte, so the held symbol is not last.
                if (node_leaf && r_osym_valid && slot_free) begin
                    out_load = 1'b1;
                    n_last   = 1'b0;
                end
            end
            ST_FLUSH: if (slot_free) out_load = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        node_we     = leaf_push || (r_state == ST_WRITE);
        node_waddr  = NW'(r_ncount);
        node_wdata  = leaf_push ? {1'b1, i_byte_value, {(2*NW){1'b0}}}
                                : {1'b0, 8'd0, r_sdata, r_right};
        node_re     = (r_state == ST_READ) || (r_state == ST_STEP && !step_stay);
        node_raddr  = (r_state == ST_STEP) ? nx : r_cur;
        stack_we    = leaf_push || (r_state == ST_WRITE);
        stack_waddr = leaf_push ? SW'(r_depth) : SW'(r_depth - (SW+1)'(2));
        stack_wdata = NW'(r_ncount);
        stack_re    = (r_state == ST_IDLE && n_state == ST_POP)
                      || (r_state == ST_POP && r_depth != (SW+1)'(1));
        stack_raddr = (r_state == ST_POP) ? SW'(r_depth - (SW+1)'(2))
                                          : SW'(r_depth - (SW+1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (node_we) r_nodes[node_waddr] <= node_wdata;
        if (node_re) r_rdata <= r_nodes[node_raddr];
        if (stack_we) r_stack[stack_waddr] <= stack_wdata;
        if (stack_re) r_sdata <= r_stack[stack_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_cfg <= '0;
        end else if (i_cfg_we) begin
            r_count_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ncount <= '0; r_depth <= '0;
            r_expect <= 1'b0; r_ready_tree <= 1'b0; r_finished <= 1'b0;
            r_root <= '0; r_cur <= '0; r_remain <= '0; r_bits <= '0;
            r_osym_valid <= 1'b0;
            o_valid <= 1'b0; o_symbol <= '0; o_last <= 1'b0;
            o_message_done <= 1'b0; o_error_code <= ERR_NONE;
        end else begin
            r_state <= n_state;
            o_valid <= n_out_valid;
            if (out_load) begin
                o_symbol <= n_symbol; o_last <= n_last;
                o_message_done <= n_done; o_error_code <= n_err;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_action) begin
                        if (r_ready_tree && !r_finished) begin
                            r_shift <= i_byte_value;
                            r_bits <= 4'(BITS_PER_BYTE);
                        end
                    end else if (accept && !r_ready_tree) begin
                        if (r_expect) begin
                            r_expect <= 1'b0;
                            if (leaf_push) begin
                                r_depth <= r_depth + 1'b1;
                                r_ncount <= r_ncount + 1'b1;
                            end
                        end else if (i_byte_value == CH_LEAF) begin
                            r_expect <= 1'b1;
                        end
                    end
                end
                ST_POP: begin
                    if (r_depth == (SW+1)'(1)) begin
                        r_root <= r_sdata; r_cur <= r_sdata; r_depth <= '0;
                        r_ready_tree <= 1'b1; r_finished <= 1'b0;
                        r_remain <= r_count_cfg;
                    end else begin
                        r_right <= r_sdata;
                    end
                end
                ST_WRITE: begin
                    r_depth <= r_depth - 1'b1;
                    r_ncount <= r_ncount + 1'b1;
                end
                ST_STEP: begin
                    if (!step_stay) r_cur <= nx;
                    r_bits <= r_bits - 1'b1;
                    r_shift <= {r_shift[6:0], 1'b0};
                end
                ST_EMIT: begin
                    if (node_leaf && emit_go) begin
                        r_osym_valid <= 1'b1;
                        r_sym <= node_sym;
                        r_done <= leaf_done;
                        r_cur <= r_root;
                        if (r_remain != '0) r_remain <= remain_dec;
                        if (leaf_done) r_finished <= 1'b1;
                    end
                end
                ST_FLUSH: if (slot_free) r_osym_valid <= 1'b0;
                default: begin
                end
            endcase
        end
    end
endmodule

[design/htld_checker.sv]
// ----------------------------------------------------------------------------
// Huffman tree load and decode: port checker
// Watches the top level ports and checks handshake and result rules.
// ----------------------------------------------------------------------------
module htld_checker
    import htld_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_ready,
    input logic [7:0] o_symbol,
    input logic       o_last,
    input logic       o_message_done,
    input logic [2:0] o_error_code
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_symbol))
        else $error("result changed while stalled");

    // Error results carry symbol 0 and are last.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_NONE |-> o_symbol == 8'd0 && o_last)
        else $error("bad error result");

    // Message done only on a final symbol.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_done |-> o_last && o_error_code == ERR_NONE)
        else $error("done without last");

    // No request is taken while a result waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request ready while a result waits");
endmodule

bind huffman_tree_load_and_decode htld_checker u_htld_checker (.*);

[test/huffman_tree_load_and_decode_check.sv]
// ----------------------------------------------------------------------------
// Huffman tree load and decode: result checker
// Watches the request and result channels and the configuration port. It keeps
// its own copy of the tree, the build stack and the symbol counter, works out
// the results of every accepted request, and compares them in order.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_check
    import htld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic        i_action,
    input  logic [7:0]  i_byte_value,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    input  logic        i_message_done,
    input  logic [2:0]  i_error_code,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = NODE_ENTRIES_DEF;
    localparam int DEPTH = STACK_ENTRIES_DEF;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       done;
        t_err       err;
    } t_result;

    t_result     results_q[$];
    logic        node_leaf[NODES];
    logic [7:0]  node_sym[NODES];
    int          node_left[NODES];
    int          node_right[NODES];
    int          stack_mem[DEPTH];
    int          node_count, stack_depth, root_node, walk_node;
    logic        leaf_symbol_next, tree_ready, finished;
    logic [31:0] symbol_count, symbols_left;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic t_result error_result(input t_err code);
        t_result r;
        r.symbol = 8'd0;
        r.last   = 1'b1;
        r.done   = 1'b0;
        r.err    = code;
        return r;
    endfunction

    task automatic load_tree_byte(input logic [7:0] b);
        if (tree_ready) begin
            return;
        end
        if (leaf_symbol_next) begin
            leaf_symbol_next = 1'b0;
            if (stack_depth >= DEPTH) begin
                results_q.push_back(error_result(ERR_OVERFLOW));
            end else if (node_count >= NODES) begin
                results_q.push_back(error_result(ERR_TABLE));
            end else begin
                node_leaf[node_count] = 1'b1;
                node_sym[node_count] = b;
                stack_mem[stack_depth] = node_count;
                stack_depth++;
                node_count++;
            end
        end else if (b == CH_LEAF) begin
            leaf_symbol_next = 1'b1;
        end else if (b == CH_JOIN) begin
            if (stack_depth == 0) begin
                results_q.push_back(error_result(ERR_UNDERFLOW));
            end else if (stack_depth == 1) begin
                root_node = stack_mem[0];
                walk_node = root_node;
                stack_depth = 0;
                tree_ready = 1'b1;
                finished = 1'b0;
                symbols_left = symbol_count;
            end else if (node_count >= NODES) begin
                results_q.push_back(error_result(ERR_TABLE));
            end else begin
                // The older entry goes left, the newer one right.
                node_leaf[node_count] = 1'b0;
                node_sym[node_count] = 8'd0;
                node_left[node_count] = stack_mem[stack_depth-2];
                node_right[node_count] = stack_mem[stack_depth-1];
                stack_mem[stack_depth-2] = node_count;
                stack_depth--;
                node_count++;
            end
        end
    endtask

    task automatic decode_data_byte(input logic [7:0] b);
        t_result r[8];
        int      n;
        int      next_node;
        logic    done;
        n = 0;
        if (!tree_ready) begin
            results_q.push_back(error_result(ERR_NO_TREE));
            return;
        end
        if (finished) begin
            return;
        end
        for (int i = 7; i >= 0; i--) begin
            done = 1'b0;
            if (node_leaf[root_node]) begin
                next_node = root_node;
            end else begin
                next_node = b[i] ? node_right[walk_node] : node_left[walk_node];
            end
            if (!node_leaf[next_node]) begin
                walk_node = next_node;
                continue;
            end
            if (symbols_left != 0) begin
                symbols_left--;
                done = (symbols_left == 0);
            end
            r[n].symbol = node_sym[next_node];
            r[n].last = 1'b0;
            r[n].done = done;
            r[n].err = ERR_NONE;
            n++;
            walk_node = root_node;
            if (done) begin
                finished = 1'b1;
                break;
            end
        end
        if (n > 0) begin
            r[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            results_q.push_back(r[i]);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            results_q.delete();
            node_count = 0;
            stack_depth = 0;
            root_node = 0;
            walk_node = 0;
            leaf_symbol_next = 1'b0;
            tree_ready = 1'b0;
            finished = 1'b0;
            symbol_count = 32'd0;
            symbols_left = 32'd0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_q.size() == 0) begin
                    report($sformatf("result sym %0h err %0d with none expected",
                                     i_symbol, i_error_code));
                end else begin
                    want = results_q.pop_front();
                    if (i_symbol !== want.symbol)
                        report($sformatf("symbol %0h, expected %0h", i_symbol, want.symbol));
                    if (i_last !== want.last)
                        report($sformatf("last %b, expected %b", i_last, want.last));
                    if (i_message_done !== want.done)
                        report($sformatf("message_done %b, expected %b",
                                         i_message_done, want.done));
                    if (i_error_code !== want.err)
                        report($sformatf("error_code %0d, expected %0d",
                                         i_error_code, want.err));
                end
            end
            if (i_cfg_we) begin
                symbol_count = i_cfg_data;
            end
            if (i_valid && i_ready_in) begin
                if (i_action) begin
                    decode_data_byte(i_byte_value);
                end else begin
                    load_tree_byte(i_byte_value);
                end
            end
        end
        o_pending = results_q.size();
    end
endmodule

[test/huffman_tree_load_and_decode_test.sv]
// ----------------------------------------------------------------------------
// Huffman tree load and decode: testbench top
// Checks error handling before the tree build (data too early, join on an
// empty stack), builds one 32-leaf tree, then decodes directed and random
// data bytes with random gaps and stalls on both channels while the checker
// compares every result.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_test
    import htld_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 40;
    localparam int TREE_LEAVES = 32;
    localparam int DATA_ITEMS = 360;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, i_action;
    logic [7:0]  i_byte_value;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        o_valid, i_ready;
    logic [7:0]  o_symbol;
    logic        o_last, o_message_done;
    logic [2:0]  o_error_code;
    int          fail_count, pending, cycles, hold_cycles;
    logic        taken, calm;

    huffman_tree_load_and_decode uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_byte_value(i_byte_value),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_symbol(o_symbol), .o_last(o_last),
        .o_message_done(o_message_done), .o_error_code(o_error_code)
    );

    huffman_tree_load_and_decode_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready),
        .i_action(i_action), .i_byte_value(i_byte_value),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_symbol(o_symbol), .i_last(o_last),
        .i_message_done(o_message_done), .i_error_code(o_error_code),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sampled with the edge itself, read back at the next falling edge.
    always @(posedge i_clk) begin
        taken <= i_valid && o_ready;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("huffman_tree_load_and_decode_test failed");
            $finish;
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready = 1'b0;
            end else begin
                i_ready = calm || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    task automatic send(input logic act, input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 27) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_action = act;
        i_byte_value = b;
        do @(negedge i_clk); while (!taken);
    endtask

    // Waits for every result, then for the block to finish any silent request.
    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [31:0] value);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic [7:0] sym;
        cycles = 0;
        hold_cycles = 0;
        calm = 1'b0;
        taken = 1'b0;
        i_valid = 1'b0;
        i_action = 1'b0;
        i_byte_value = 8'd0;
        i_cfg_we = 1'b0;
        i_cfg_data = 32'd0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_count(32'hFFFF_FFFF);
        // Data too early, join on an empty stack, characters that are ignored.
        send(1'b1, 8'h00);
        send(1'b1, 8'hFF);
        send(1'b0, CH_JOIN);
        send(1'b0, 8'h41);
        send(1'b0, 8'hFF);
        send(1'b0, 8'h00);

        // Push the leaves; the symbols include both marker characters.
        for (int i = 0; i < TREE_LEAVES; i++) begin
            case (i)
                0: sym = 8'h00;
                1: sym = 8'hFF;
                2: sym = CH_LEAF;
                3: sym = CH_JOIN;
                default: sym = 8'($urandom_range(0, 255));
            endcase
            send(1'b0, CH_LEAF);
            send(1'b0, sym);
        end
        send(1'b0, 8'h37);
        for (int i = 0; i < TREE_LEAVES - 1; i++) begin
            send(1'b0, CH_JOIN);
        end

        write_count(32'd0);
        write_count(32'($urandom_range(1000, 1200)));
        send(1'b0, CH_JOIN);
        // The tree is set; further tree bytes are ignored.
        send(1'b0, CH_LEAF);
        send(1'b0, CH_JOIN);
        send(1'b1, 8'h00);
        send(1'b1, 8'hFF);
        send(1'b1, 8'hAA);
        send(1'b1, 8'h80);
        send(1'b1, 8'h7F);

        for (int i = 0; i < DATA_ITEMS; i++) begin
            if (i == 80) begin
                hold_cycles = 400;
            end
            if (i == 180) begin
                // The count is sampled only at the root, so this must not matter.
                write_count(32'hFFFF_FFFF);
                write_count(32'd1);
            end
            calm = (i >= 220 && i < 290);
            if ($urandom_range(0, 99) < 8) begin
                send(1'b0, 8'($urandom_range(0, 255)));
            end else begin
                send(1'b1, 8'($urandom_range(0, 255)));
            end
        end
        calm = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("huffman_tree_load_and_decode_test passed");
        end else begin
            $display("huffman_tree_load_and_decode_test failed");
        end
        $finish;
    end
endmodule
